// ===== src/rwpr_pkg.sv =====
// Shared constants, register codes and the point payload type of the point replicator.
`timescale 1ns / 1ps

package rwpr_pkg;

	localparam int MAX_COPIES      = 64;
	localparam int COORD_FRAC_BITS = 16;
	localparam int CNT_W           = $clog2(MAX_COPIES + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Rotation pivot, held with 24 fraction bits and rounded to the coordinate format.
	localparam longint PIVOT_X_Q24 = -64'sd253600459;
	localparam longint PIVOT_Y_Q24 = 64'sd199583691;
	localparam int     PIVOT_SHIFT = 24 - COORD_FRAC_BITS;
	localparam longint PIVOT_HALF  = (PIVOT_SHIFT == 0) ? 64'sd0 : (64'sd1 <<< (PIVOT_SHIFT - 1));
	localparam longint PIVOT_X     = (PIVOT_X_Q24 + PIVOT_HALF) >>> PIVOT_SHIFT;
	localparam longint PIVOT_Y     = (PIVOT_Y_Q24 + PIVOT_HALF) >>> PIVOT_SHIFT;

	// cos(45) = sin(45) in Q0.30.
	localparam longint COS45_Q30 = 64'sd759250125;
	localparam int     COS_W     = 31;
	localparam int     COS_SHIFT = 30;

	localparam int ONE_Q16     = 65536;
	localparam int RAND_SHIFT  = 16;
	localparam int T_INT_SHIFT = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DENSITY_RATIO = 3'd0,
		REG_WINDOW_X_LOW  = 3'd1,
		REG_WINDOW_X_HIGH = 3'd2,
		REG_CENTER_Y      = 3'd3,
		REG_CENTER_Z      = 3'd4,
		REG_INV_RADIUS_Y  = 3'd5,
		REG_INV_RADIUS_Z  = 3'd6
	} cfg_reg_t;

	// One point as it is emitted: defaults for absent normals and colors already applied.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [31:0]        nx;
		logic [31:0]        ny;
		logic [31:0]        nz;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
	} point_t;

endpackage

// ===== src/rwpr_if.sv =====
// Valid/ready channel interfaces for input points and emitted copies.
`timescale 1ns / 1ps

interface rwpr_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic signed [31:0] z_coord;
	logic [31:0]        normal_x;
	logic [31:0]        normal_y;
	logic [31:0]        normal_z;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [15:0]        random_value;
	logic               has_normal;
	logic               has_color;

	modport source (
		output valid, x_coord, y_coord, z_coord, normal_x, normal_y, normal_z,
		       red, green, blue, random_value, has_normal, has_color,
		input  ready
	);
	modport sink (
		input  valid, x_coord, y_coord, z_coord, normal_x, normal_y, normal_z,
		       red, green, blue, random_value, has_normal, has_color,
		output ready
	);
endinterface

interface rwpr_copy_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic [31:0]        out_normal_x;
	logic [31:0]        out_normal_y;
	logic [31:0]        out_normal_z;
	logic [7:0]         out_red;
	logic [7:0]         out_green;
	logic [7:0]         out_blue;
	logic               last_copy;

	modport source (
		output valid, out_x, out_y, out_z, out_normal_x, out_normal_y, out_normal_z,
		       out_red, out_green, out_blue, last_copy,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_normal_x, out_normal_y, out_normal_z,
		       out_red, out_green, out_blue, last_copy,
		output ready
	);
endinterface

// ===== src/region_weighted_point_replicator.sv =====
// Top level of the region-weighted point replicator: weight pipeline and copy output stage.
`timescale 1ns / 1ps

// Channel   Dir  Transfer when         Carries
// point_ch  in   valid && ready        one point, its random fraction and attribute flags
// copy_ch   out  valid && ready        one copy of a point, last_copy on the final one
// cfg_*     in   cfg_we at clock edge  register index and write data, no read-back
//
// An accepted point walks six register stages (three of them end in a multiplier)
// before it reaches the output register.
// A point with n copies holds the output register until its n copies are sent, one copy
// per cycle while copy_ch is ready; points with zero copies are dropped at stage six.
// Reset clears the stage valid bits and the output valid and count, and loads the register
// defaults. A stall on copy_ch backs up stage by stage; no stage loses or repeats a point.

module region_weighted_point_replicator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rwpr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rwpr_pkg::CFG_DATA_W-1:0]   cfg_data,
	rwpr_point_if.sink                        point_ch,
	rwpr_copy_if.source                       copy_ch
);
	import rwpr_pkg::*;

	// Datapath widths. Differences grow by one bit per add, products by the sum.
	localparam int DIFF_W    = 34;
	localparam int PROD_W    = DIFF_W + COS_W;
	localparam int ROT_W     = PROD_W - COS_SHIFT;
	localparam int DYA_W     = ROT_W + 1;
	localparam int DZA_W     = 34;
	localparam int INV_W     = 18;
	localparam int RATIO_W   = 22;
	localparam int TY_PROD_W = DYA_W + INV_W;
	localparam int TZ_PROD_W = DZA_W + INV_W;
	localparam int TY_W      = TY_PROD_W - COORD_FRAC_BITS;
	localparam int TZ_W      = TZ_PROD_W - COORD_FRAC_BITS;
	localparam int SUM_W     = ((TY_W > TZ_W) ? TY_W : TZ_W) + 1;
	localparam int WGT_W     = 17;
	localparam int T_W       = RATIO_W + WGT_W;
	localparam int N_W       = T_W - T_INT_SHIFT;
	localparam int CR_W      = ((N_W > CNT_W) ? N_W : CNT_W) + 1;

	localparam logic signed [DIFF_W-1:0] PX_D  = DIFF_W'(PIVOT_X);
	localparam logic signed [DIFF_W-1:0] PY_D  = DIFF_W'(PIVOT_Y);
	localparam logic signed [ROT_W-1:0]  PX_R  = ROT_W'(PIVOT_X);
	localparam logic signed [ROT_W-1:0]  PY_R  = ROT_W'(PIVOT_Y);
	localparam logic signed [COS_W-1:0]  COS_C = COS_W'(COS45_Q30);

	// Configuration registers.
	logic [RATIO_W-1:0]  density_ratio_q;
	logic signed [31:0]  window_x_low_q;
	logic signed [31:0]  window_x_high_q;
	logic signed [31:0]  center_y_q;
	logic signed [31:0]  center_z_q;
	logic [INV_W-1:0]    inv_radius_y_q;
	logic [INV_W-1:0]    inv_radius_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			density_ratio_q <= RATIO_W'(65536);
			window_x_low_q  <= -32'sd2240872;
			window_x_high_q <= 32'sd325156;
			center_y_q      <= 32'sd714087;
			center_z_q      <= 32'sd362702;
			inv_radius_y_q  <= INV_W'(7276);
			inv_radius_z_q  <= INV_W'(11015);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DENSITY_RATIO: density_ratio_q <= cfg_data[RATIO_W-1:0];
				REG_WINDOW_X_LOW:  window_x_low_q  <= signed'(cfg_data);
				REG_WINDOW_X_HIGH: window_x_high_q <= signed'(cfg_data);
				REG_CENTER_Y:      center_y_q      <= signed'(cfg_data);
				REG_CENTER_Z:      center_z_q      <= signed'(cfg_data);
				REG_INV_RADIUS_Y:  inv_radius_y_q  <= cfg_data[INV_W-1:0];
				REG_INV_RADIUS_Z:  inv_radius_z_q  <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valid bits and the ready chain. A stage takes new data when it is
	// empty or when the stage after it takes its contents.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic out_v_q;
	logic [CNT_W-1:0] rem_q;
	logic out_free;
	logic [CNT_W-1:0] cnt6;
	logic load_ok;

	assign out_free = !out_v_q || (copy_ch.ready && rem_q == CNT_W'(1));
	assign load_ok  = (cnt6 == '0) || out_free;
	assign en_s6    = !v_s6 || load_ok;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign point_ch.ready = en_s1;

	// Stage 1 input: pivot-relative differences and the z distance; defaults applied.
	logic signed [DIFF_W-1:0] dx0, dy0, dz0;
	logic [DZA_W-1:0] dz_abs0;
	point_t pt0;

	always_comb begin
		dx0     = DIFF_W'(point_ch.x_coord) - PX_D;
		dy0     = DIFF_W'(point_ch.y_coord) - PY_D;
		dz0     = DIFF_W'(point_ch.z_coord) - DIFF_W'(center_z_q);
		dz_abs0 = dz0[DIFF_W-1] ? DZA_W'(-dz0) : DZA_W'(dz0);
		pt0.x   = point_ch.x_coord;
		pt0.y   = point_ch.y_coord;
		pt0.z   = point_ch.z_coord;
		pt0.nx  = point_ch.has_normal ? point_ch.normal_x : 32'd0;
		pt0.ny  = point_ch.has_normal ? point_ch.normal_y : 32'd0;
		pt0.nz  = point_ch.has_normal ? point_ch.normal_z : 32'd0;
		pt0.r   = point_ch.has_color ? point_ch.red : 8'hFF;
		pt0.g   = point_ch.has_color ? point_ch.green : 8'hFF;
		pt0.b   = point_ch.has_color ? point_ch.blue : 8'hFF;
	end

	// Pipeline payload registers.
	point_t pt_s1, pt_s2, pt_s3, pt_s4, pt_s5, pt_s6;
	logic [15:0] rnd_s1, rnd_s2, rnd_s3, rnd_s4, rnd_s5, rnd_s6;
	logic signed [DIFF_W-1:0] dxmy_s1, dxpy_s1;
	logic [DZA_W-1:0]         dz_abs_s1;
	logic signed [PROD_W-1:0] prx_s2, pry_s2;
	logic [TZ_PROD_W-1:0]     tz_prod_s2;
	logic                     in_win_s3, in_win_s4;
	logic [DYA_W-1:0]         dy_abs_s3;
	logic [TZ_W-1:0]          tz_s3, tz_s4;
	logic [TY_PROD_W-1:0]     ty_prod_s4;
	logic [WGT_W-1:0]         weight_s5;
	logic [T_W-1:0]           t_s6;

	// Stage 3 input: rotated coordinates, window test and the rotated-y distance.
	logic signed [ROT_W-1:0] rx2, ry2;
	logic signed [DYA_W-1:0] dyd2;
	logic                    in_win2;
	logic [DYA_W-1:0]        dy_abs2;

	always_comb begin
		rx2     = ROT_W'(prx_s2 >>> COS_SHIFT) + PX_R;
		ry2     = ROT_W'(pry_s2 >>> COS_SHIFT) + PY_R;
		in_win2 = (rx2 >= ROT_W'(window_x_low_q)) && (rx2 <= ROT_W'(window_x_high_q));
		dyd2    = DYA_W'(ry2) - DYA_W'(center_y_q);
		dy_abs2 = dyd2[DYA_W-1] ? DYA_W'(-dyd2) : DYA_W'(dyd2);
	end

	// Stage 5 input: the diamond distance and the clamped weight.
	logic [SUM_W-1:0] dist4;
	logic [WGT_W-1:0] weight4;

	always_comb begin
		dist4   = SUM_W'(ty_prod_s4 >> COORD_FRAC_BITS) + SUM_W'(tz_s4);
		weight4 = (!in_win_s4 || dist4 >= SUM_W'(ONE_Q16)) ? '0
		          : WGT_W'(SUM_W'(ONE_Q16) - dist4);
	end

	// Copy count: whole part of t, one more if the fraction beats rnd, capped at MAX_COPIES.
	logic [N_W-1:0]  n6;
	logic            extra6;
	logic [CR_W-1:0] cnt_raw6;

	always_comb begin
		n6       = t_s6[T_W-1:T_INT_SHIFT];
		extra6   = t_s6[T_INT_SHIFT-1:0] > ({16'd0, rnd_s6} << RAND_SHIFT);
		cnt_raw6 = CR_W'(n6) + CR_W'(extra6);
		cnt6     = (cnt_raw6 > CR_W'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : CNT_W'(cnt_raw6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= point_ch.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pt_s1     <= pt0;
			rnd_s1    <= point_ch.random_value;
			dxmy_s1   <= dx0 - dy0;
			dxpy_s1   <= dx0 + dy0;
			dz_abs_s1 <= dz_abs0;
		end
		if (en_s2) begin
			pt_s2      <= pt_s1;
			rnd_s2     <= rnd_s1;
			prx_s2     <= PROD_W'(dxmy_s1) * PROD_W'(COS_C);
			pry_s2     <= PROD_W'(dxpy_s1) * PROD_W'(COS_C);
			tz_prod_s2 <= TZ_PROD_W'(dz_abs_s1) * TZ_PROD_W'(inv_radius_z_q);
		end
		if (en_s3) begin
			pt_s3     <= pt_s2;
			rnd_s3    <= rnd_s2;
			in_win_s3 <= in_win2;
			dy_abs_s3 <= dy_abs2;
			tz_s3     <= TZ_W'(tz_prod_s2 >> COORD_FRAC_BITS);
		end
		if (en_s4) begin
			pt_s4      <= pt_s3;
			rnd_s4     <= rnd_s3;
			in_win_s4  <= in_win_s3;
			tz_s4      <= tz_s3;
			ty_prod_s4 <= TY_PROD_W'(dy_abs_s3) * TY_PROD_W'(inv_radius_y_q);
		end
		if (en_s5) begin
			pt_s5     <= pt_s4;
			rnd_s5    <= rnd_s4;
			weight_s5 <= weight4;
		end
		if (en_s6) begin
			pt_s6  <= pt_s5;
			rnd_s6 <= rnd_s5;
			t_s6   <= T_W'(density_ratio_q) * T_W'(weight_s5);
		end
	end

	// Output register. It repeats the held point, counting down the copies left;
	// on the last copy's transfer it takes the next point with a nonzero count.
	point_t pt_q;
	logic   load_out;

	assign load_out = out_free && v_s6 && (cnt6 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			rem_q   <= '0;
		end else if (out_v_q && copy_ch.ready && rem_q != CNT_W'(1)) begin
			rem_q <= rem_q - CNT_W'(1);
		end else if (out_free) begin
			out_v_q <= load_out;
			rem_q   <= load_out ? cnt6 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pt_q <= pt_s6;
		end
	end

	assign copy_ch.valid        = out_v_q;
	assign copy_ch.out_x        = pt_q.x;
	assign copy_ch.out_y        = pt_q.y;
	assign copy_ch.out_z        = pt_q.z;
	assign copy_ch.out_normal_x = pt_q.nx;
	assign copy_ch.out_normal_y = pt_q.ny;
	assign copy_ch.out_normal_z = pt_q.nz;
	assign copy_ch.out_red      = pt_q.r;
	assign copy_ch.out_green    = pt_q.g;
	assign copy_ch.out_blue     = pt_q.b;
	assign copy_ch.last_copy    = (rem_q == CNT_W'(1));

	// A held copy always has at least one copy left to send.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> rem_q != '0)
		else $error("output register valid with no copies left");

	// After a copy that is not the last, the next copy of the same point follows.
	a_copy_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(copy_ch.valid && copy_ch.ready && !copy_ch.last_copy) |=> copy_ch.valid)
		else $error("copy sequence broken before the last copy");

	// The weight never exceeds one.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> weight_s5 <= WGT_W'(ONE_Q16))
		else $error("weight above one");

endmodule
